// File: design/svn_pkg.sv
// ----------------------------------------------------------------------------
// svn_pkg: shared types and constants for the smooth vertex normal block
// Beat formats, command and status codes, store geometry and the saturating
// narrow helper used by the accumulate path.
// ----------------------------------------------------------------------------
`default_nettype none

package svn_pkg;

  localparam int MaxVerts  = 1024;
  localparam int CoordBits = 24;
  localparam int IdxW      = $clog2(MaxVerts);
  localparam int AccW      = 56;
  localparam int VcountW   = 11;
  localparam int IndexW    = 16;
  localparam int NrmW      = 16;

  // Edge, product and cross product widths follow the coordinate width.
  localparam int EdgeW  = CoordBits + 1;
  localparam int ProdW  = 2 * EdgeW;
  localparam int CrossW = ProdW + 1;
  localparam int SatW   = (CrossW > AccW + 1) ? CrossW : AccW + 1;

  localparam int PosWordW = 3 * CoordBits;
  localparam int AccWordW = 3 * AccW;

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdFace  = 2'd1,
    CmdRead  = 2'd2,
    CmdClear = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatSkip  = 2'd1,
    StatRange = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                  command;
    logic [IndexW-1:0]           index_a;
    logic [IndexW-1:0]           index_b;
    logic [IndexW-1:0]           index_c;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [NrmW-1:0] normal_x;
    logic signed [NrmW-1:0] normal_y;
    logic signed [NrmW-1:0] normal_z;
    logic                   zero_normal;
  } out_beat_t;

  typedef struct packed {
    logic                   zero;
    logic signed [NrmW-1:0] nx;
    logic signed [NrmW-1:0] ny;
    logic signed [NrmW-1:0] nz;
  } norm_res_t;

  // Clamp a wide signed value into the accumulator range.
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [SatW-1:0] v);
    logic [SatW-AccW:0] hi;
    hi = v[SatW-1:AccW-1];
    if ((&hi) || !(|hi)) begin
      return v[AccW-1:0];
    end else if (v[SatW-1]) begin
      return {1'b1, {(AccW-1){1'b0}}};
    end else begin
      return {1'b0, {(AccW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// File: design/svn_ram.sv
// ----------------------------------------------------------------------------
// svn_ram: single write port, single read port synchronous memory
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module svn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/svn_norm.sv
// ----------------------------------------------------------------------------
// svn_norm: scale an accumulated normal to unit length in Q1.15
// Block-normalize the magnitudes one bit a cycle, square, take a bit-serial
// integer root, then run three restoring dividers side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module svn_norm (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [svn_pkg::AccW-1:0]   acc_x_i,
  input  wire logic signed [svn_pkg::AccW-1:0]   acc_y_i,
  input  wire logic signed [svn_pkg::AccW-1:0]   acc_z_i,
  output logic                                   done_o,
  output svn_pkg::norm_res_t                     res_o
);
  import svn_pkg::*;

  localparam int NW    = 31;             // normalized magnitude width
  localparam int SqW   = 2 * NW + 2;     // sum of three squares
  localparam int QW    = NrmW + 1;       // quotient bits
  localparam int RemW  = NW + NrmW + 1;  // (m << 16) + L
  localparam int DshW  = SqW / 2 + 1 + NrmW;
  localparam int CntW  = $clog2(QW);

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SUM, N_ROOT, N_DIV, N_DONE
  } nstate_e;

  nstate_e               state_q;
  logic [AccW-1:0]       m_q   [3];
  logic                  neg_q [3];
  logic [2*NW-1:0]       sq_q  [3];
  logic [SqW-1:0]        v_q, r_q, b_q;
  logic [RemW-1:0]       rem_q [3];
  logic [QW-1:0]         quo_q [3];
  logic [DshW-1:0]       dsh_q;
  logic [CntW-1:0]       cnt_q;
  logic                  done_q;
  norm_res_t             res_q;

  logic [AccW-1:0]       mag_in [3];
  logic signed [AccW-1:0] acc_in [3];
  logic                  in_zero;
  logic                  big, tiny;
  logic [SqW-1:0]        root_t;
  logic [NrmW-1:0]       comp [3];

  assign acc_in[0] = acc_x_i;
  assign acc_in[1] = acc_y_i;
  assign acc_in[2] = acc_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = acc_in[k][AccW-1] ? (~acc_in[k] + AccW'(1)) : acc_in[k];
    end
    in_zero = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
    big   = (|m_q[0][AccW-1:NW]) | (|m_q[1][AccW-1:NW]) | (|m_q[2][AccW-1:NW]);
    tiny  = !(m_q[0][NW-1] | m_q[1][NW-1] | m_q[2][NW-1]);
    root_t = r_q + b_q;
    for (int k = 0; k < 3; k++) begin
      logic [NrmW-1:0] cl;
      cl = (quo_q[k] > QW'(2**(NrmW-1) - 1)) ? NrmW'(2**(NrmW-1) - 1) : quo_q[k][NrmW-1:0];
      comp[k] = neg_q[k] ? (~cl + NrmW'(1)) : cl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= (state_q == N_DONE) || ((state_q == N_IDLE) && start_i && in_zero);
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            for (int k = 0; k < 3; k++) begin
              m_q[k]   <= mag_in[k];
              neg_q[k] <= acc_in[k][AccW-1];
            end
            if (in_zero) begin
              res_q  <= '{zero: 1'b1, nx: '0, ny: '0, nz: '0};
            end else begin
              state_q <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // Bring the largest magnitude into [2^30, 2^31); right shifts truncate.
          if (big) begin
            for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
          end else if (tiny) begin
            for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
          end else begin
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          for (int k = 0; k < 3; k++) sq_q[k] <= m_q[k][NW-1:0] * m_q[k][NW-1:0];
          state_q <= N_SUM;
        end
        N_SUM: begin
          v_q     <= SqW'(sq_q[0]) + SqW'(sq_q[1]) + SqW'(sq_q[2]);
          r_q     <= '0;
          b_q     <= SqW'(1) << (SqW - 2);
          state_q <= N_ROOT;
        end
        N_ROOT: begin
          if (b_q == '0) begin
            // r_q holds the floor root L; set up (m*2^16 + L) / (2L).
            for (int k = 0; k < 3; k++) begin
              rem_q[k] <= (RemW'(m_q[k][NW-1:0]) << NrmW) + RemW'(r_q);
              quo_q[k] <= '0;
            end
            dsh_q   <= DshW'(r_q) << (NrmW + 1);
            cnt_q   <= CntW'(QW - 1);
            state_q <= N_DIV;
          end else begin
            if (v_q >= root_t) begin
              v_q <= v_q - root_t;
              r_q <= (r_q >> 1) + b_q;
            end else begin
              r_q <= r_q >> 1;
            end
            b_q <= b_q >> 2;
          end
        end
        N_DIV: begin
          for (int k = 0; k < 3; k++) begin
            if (DshW'(rem_q[k]) >= dsh_q) begin
              rem_q[k] <= rem_q[k] - dsh_q[RemW-1:0];
              quo_q[k] <= {quo_q[k][QW-2:0], 1'b1};
            end else begin
              quo_q[k] <= {quo_q[k][QW-2:0], 1'b0};
            end
          end
          dsh_q <= dsh_q >> 1;
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == '0) state_q <= N_DONE;
        end
        N_DONE: begin
          res_q   <= '{zero: 1'b0, nx: comp[0], ny: comp[1], nz: comp[2]};
          state_q <= N_IDLE;
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// File: design/smooth_vertex_normals.sv
// ----------------------------------------------------------------------------
// smooth_vertex_normals: area-weighted smooth vertex normal generator
// Stores Q12.12 vertex positions, sums face cross products into per-vertex
// accumulators and returns unit-length Q1.15 normals on request.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------
//  in       | to block  | in_valid / in_ready | in_beat_t  (command, indices)
//  out      | from blk  | out_valid/out_ready | out_beat_t (status, normal)
//  apb      | to block  | psel/penable/pready | vertex_count at byte 0
//
//  A clear walks all MaxVerts accumulator entries. A read on a nonzero sum
//  block-shifts one bit per cycle, then runs the root steps and 17 divide
//  steps; a zero sum skips the shift, root and divide. Face cost is set by
//  the shared position and accumulator ports.
//  After reset a clearing pass zeroes all MaxVerts (1024) accumulator
//  entries; in_ready stays low during it.
//  One beat is worked on at a time; the result waits in the output register
//  while the next input beat is taken. A stalled output holds the sequencer
//  in its final state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_vertex_normals (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire svn_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output svn_pkg::out_beat_t      out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import svn_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_PRD_A, S_PRD_B, S_PRD_C, S_PLATCH,
    S_EDGE, S_MUL, S_CROSS, S_ACC_RD, S_ACC_WR, S_RD_ISSUE, S_RD_LATCH,
    S_NORM, S_CLEAR, S_DONE
  } state_e;

  state_e                  state_q;
  in_beat_t                beat_q;
  logic [VcountW-1:0]      vcount_q;
  logic [1:0]              status_q;
  norm_res_t               nres_q;
  logic [IdxW-1:0]         cnt_q;
  logic [1:0]              corner_q;
  logic                    out_valid_q;
  out_beat_t               out_q;

  logic [PosWordW-1:0]     pa_q, pb_q, pc_q;
  logic signed [EdgeW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [ProdW-1:0] p_q [6];
  logic signed [AccW-1:0]  fx_q, fy_q, fz_q;

  // memory ports
  logic                    pos_we;
  logic [IdxW-1:0]         pos_raddr;
  logic [PosWordW-1:0]     pos_rdata;
  logic                    acc_we;
  logic [IdxW-1:0]         acc_waddr, acc_raddr, corner_idx;
  logic [AccWordW-1:0]     acc_wdata, acc_rdata;

  logic                    va, vb, vc;
  logic                    norm_start, norm_done;
  norm_res_t               norm_res;
  logic signed [AccW-1:0]  ax, ay, az, sx, sy, sz;
  logic                    out_free;

  function automatic logic idx_ok(input logic [IndexW-1:0] idx,
                                  input logic [VcountW-1:0] vcnt);
    return ({1'b0, idx} < (IndexW+1)'(MaxVerts)) &&
           ({1'b0, idx} < (IndexW+1)'(vcnt));
  endfunction

  assign va = idx_ok(beat_q.index_a, vcount_q);
  assign vb = idx_ok(beat_q.index_b, vcount_q);
  assign vc = idx_ok(beat_q.index_c, vcount_q);

  // APB: single register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(vcount_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      vcount_q <= pwdata[VcountW-1:0];
    end
  end

  svn_ram #(.Width(PosWordW), .Depth(MaxVerts)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (beat_q.index_a[IdxW-1:0]),
    .wdata_i ({beat_q.coord_x, beat_q.coord_y, beat_q.coord_z}),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  svn_ram #(.Width(AccWordW), .Depth(MaxVerts)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  svn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .acc_x_i (ax),
    .acc_y_i (ay),
    .acc_z_i (az),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  assign ax = acc_rdata[3*AccW-1:2*AccW];
  assign ay = acc_rdata[2*AccW-1:AccW];
  assign az = acc_rdata[AccW-1:0];

  // Saturating read-modify-write of one corner's accumulator.
  assign sx = sat_acc(SatW'(ax) + SatW'(fx_q));
  assign sy = sat_acc(SatW'(ay) + SatW'(fy_q));
  assign sz = sat_acc(SatW'(az) + SatW'(fz_q));

  always_comb begin
    case (corner_q)
      2'd0:    corner_idx = beat_q.index_a[IdxW-1:0];
      2'd1:    corner_idx = beat_q.index_b[IdxW-1:0];
      default: corner_idx = beat_q.index_c[IdxW-1:0];
    endcase

    case (state_q)
      S_PRD_B: pos_raddr = beat_q.index_b[IdxW-1:0];
      S_PRD_C: pos_raddr = beat_q.index_c[IdxW-1:0];
      default: pos_raddr = beat_q.index_a[IdxW-1:0];
    endcase

    pos_we     = (state_q == S_DISPATCH) && (cmd_e'(beat_q.command) == CmdWrite) && va;
    acc_raddr  = corner_idx;
    acc_we     = (state_q == S_ACC_WR) || (state_q == S_CLEAR) || (state_q == S_INIT);
    acc_waddr  = (state_q == S_ACC_WR) ? corner_idx : cnt_q;
    acc_wdata  = (state_q == S_ACC_WR) ? {sx, sy, sz} : '0;
    norm_start = (state_q == S_RD_LATCH);
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StatOk;
    end else begin
      // drop the output beat once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;

      case (state_q)
        S_INIT: begin
          cnt_q <= cnt_q + IdxW'(1);
          if (cnt_q == IdxW'(MaxVerts - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            beat_q  <= in_data_i;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          nres_q   <= '0;
          corner_q <= '0;
          cnt_q    <= '0;
          case (cmd_e'(beat_q.command))
            CmdWrite: begin
              status_q <= va ? StatOk : StatRange;
              state_q  <= S_DONE;
            end
            CmdFace: begin
              if (va && vb && vc) begin
                status_q <= StatOk;
                state_q  <= S_PRD_A;
              end else begin
                status_q <= StatSkip;
                state_q  <= S_DONE;
              end
            end
            CmdRead: begin
              if (va) begin
                status_q <= StatOk;
                state_q  <= S_RD_ISSUE;
              end else begin
                status_q <= StatRange;
                state_q  <= S_DONE;
              end
            end
            default: begin
              status_q <= StatOk;
              state_q  <= S_CLEAR;
            end
          endcase
        end
        // fetch the three corner positions through the one read port
        S_PRD_A: state_q <= S_PRD_B;
        S_PRD_B: begin
          pa_q    <= pos_rdata;
          state_q <= S_PRD_C;
        end
        S_PRD_C: begin
          pb_q    <= pos_rdata;
          state_q <= S_PLATCH;
        end
        S_PLATCH: begin
          pc_q    <= pos_rdata;
          state_q <= S_EDGE;
        end
        S_EDGE: begin
          ux_q <= EdgeW'($signed(pb_q[3*CoordBits-1:2*CoordBits]))
                - EdgeW'($signed(pa_q[3*CoordBits-1:2*CoordBits]));
          uy_q <= EdgeW'($signed(pb_q[2*CoordBits-1:CoordBits]))
                - EdgeW'($signed(pa_q[2*CoordBits-1:CoordBits]));
          uz_q <= EdgeW'($signed(pb_q[CoordBits-1:0]))
                - EdgeW'($signed(pa_q[CoordBits-1:0]));
          vx_q <= EdgeW'($signed(pc_q[3*CoordBits-1:2*CoordBits]))
                - EdgeW'($signed(pa_q[3*CoordBits-1:2*CoordBits]));
          vy_q <= EdgeW'($signed(pc_q[2*CoordBits-1:CoordBits]))
                - EdgeW'($signed(pa_q[2*CoordBits-1:CoordBits]));
          vz_q <= EdgeW'($signed(pc_q[CoordBits-1:0]))
                - EdgeW'($signed(pa_q[CoordBits-1:0]));
          state_q <= S_MUL;
        end
        S_MUL: begin
          p_q[0] <= uy_q * vz_q;
          p_q[1] <= uz_q * vy_q;
          p_q[2] <= uz_q * vx_q;
          p_q[3] <= ux_q * vz_q;
          p_q[4] <= ux_q * vy_q;
          p_q[5] <= uy_q * vx_q;
          state_q <= S_CROSS;
        end
        S_CROSS: begin
          fx_q <= sat_acc(SatW'(CrossW'(p_q[0]) - CrossW'(p_q[1])));
          fy_q <= sat_acc(SatW'(CrossW'(p_q[2]) - CrossW'(p_q[3])));
          fz_q <= sat_acc(SatW'(CrossW'(p_q[4]) - CrossW'(p_q[5])));
          state_q <= S_ACC_RD;
        end
        // one corner at a time: the write lands before the next read issues,
        // so repeated corners see their own update
        S_ACC_RD: state_q <= S_ACC_WR;
        S_ACC_WR: begin
          if (corner_q == 2'd2) begin
            state_q <= S_DONE;
          end else begin
            corner_q <= corner_q + 2'd1;
            state_q  <= S_ACC_RD;
          end
        end
        S_RD_ISSUE: state_q <= S_RD_LATCH;
        S_RD_LATCH: state_q <= S_NORM;
        S_NORM: begin
          if (norm_done) begin
            nres_q  <= norm_res;
            state_q <= S_DONE;
          end
        end
        S_CLEAR: begin
          cnt_q <= cnt_q + IdxW'(1);
          if (cnt_q == IdxW'(MaxVerts - 1)) state_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register frees
          if (out_free) begin
            out_q.status      <= status_q;
            out_q.normal_x    <= nres_q.nx;
            out_q.normal_y    <= nres_q.ny;
            out_q.normal_z    <= nres_q.nz;
            out_q.zero_normal <= nres_q.zero;
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: tb/tb_smooth_vertex_normals.sv
// ----------------------------------------------------------------------------
// tb_smooth_vertex_normals: self-checking bench for the smooth normal block
// Feeds vertex writes, face accumulations, normal reads and clears through
// the valid/ready input channel across several vertex_count settings. A local
// predictor tracks positions and accumulators, and every output beat is
// compared field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_smooth_vertex_normals;
  import svn_pkg::*;

  localparam int  NumVerts  = 1024;
  localparam longint AccHi  = (64'sd1 <<< 55) - 1;
  localparam longint AccLo  = -AccHi - 1;
  localparam int  CycleLimit = 3_000_000;
  localparam int  RegVcount = 0;

  // DUT inputs, all driven to known values from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_beat_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_beat_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  smooth_vertex_normals i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: mirrors the vertex store, the accumulators and the
  // vertex_count register of the block.
  longint   vert_x [NumVerts];
  longint   vert_y [NumVerts];
  longint   vert_z [NumVerts];
  longint   sum_x  [NumVerts];
  longint   sum_y  [NumVerts];
  longint   sum_z  [NumVerts];
  int       vcount_model = 0;

  in_beat_t  pending_beats[$];
  out_beat_t expected_beats[$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors    = 0;
  int cycles    = 0;
  int beats_in  = 0;
  int beats_out = 0;
  int cmd_seen [4];
  int zero_reads = 0;
  int sat_reads  = 0;

  // Generator bookkeeping: which vertices hold a written position, so that a
  // face never names a vertex whose position is still undefined.
  bit written [NumVerts];
  int written_list[$];

  function automatic bit index_ok(input longint unsigned idx);
    return idx < longint'(vcount_model) && idx < NumVerts;
  endfunction

  function automatic longint clamp_acc(input longint v);
    if (v > AccHi) return AccHi;
    if (v < AccLo) return AccLo;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale one accumulator to unit length in Q1.15.
  function automatic out_beat_t unit_normal(input longint cx, input longint cy,
                                            input longint cz);
    longint          c [3];
    longint unsigned m [3];
    longint unsigned mx, t, sq, root, q;
    logic [15:0]     n [3];
    int              len;
    out_beat_t       r;
    r = '0;
    c[0] = cx; c[1] = cy; c[2] = cz;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = (c[k] < 0) ? longint'(0) - c[k] : c[k];
      if (m[k] > mx) mx = m[k];
    end
    if (mx == 0) begin
      r.zero_normal = 1'b1;
      return r;
    end
    len = 0;
    t = mx;
    while (t != 0) begin
      len++;
      t = t >> 1;
    end
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      if (len > 31) m[k] = m[k] >> (len - 31);
      else m[k] = m[k] << (31 - len);
      sq += m[k] * m[k];
    end
    root = int_sqrt(sq);
    for (int k = 0; k < 3; k++) begin
      q = (2 * m[k] * 32768 + root) / (2 * root);
      if (q > 32767) q = 32767;
      n[k] = (c[k] < 0) ? 16'(0) - 16'(q) : 16'(q);
    end
    r.normal_x = n[0];
    r.normal_y = n[1];
    r.normal_z = n[2];
    return r;
  endfunction

  // Apply one accepted command to the predictor and return its result beat.
  function automatic out_beat_t apply_command(input in_beat_t b);
    out_beat_t r;
    longint    ux, uy, uz, vx, vy, vz, fx, fy, fz;
    int        corner [3];
    r = '0;
    case (cmd_e'(b.command))
      CmdWrite: begin
        if (index_ok(b.index_a)) begin
          vert_x[b.index_a] = longint'(b.coord_x);
          vert_y[b.index_a] = longint'(b.coord_y);
          vert_z[b.index_a] = longint'(b.coord_z);
        end else begin
          r.status = StatRange;
        end
      end
      CmdFace: begin
        if (index_ok(b.index_a) && index_ok(b.index_b) && index_ok(b.index_c)) begin
          ux = vert_x[b.index_b] - vert_x[b.index_a];
          uy = vert_y[b.index_b] - vert_y[b.index_a];
          uz = vert_z[b.index_b] - vert_z[b.index_a];
          vx = vert_x[b.index_c] - vert_x[b.index_a];
          vy = vert_y[b.index_c] - vert_y[b.index_a];
          vz = vert_z[b.index_c] - vert_z[b.index_a];
          // edges stay below 2^25, so the products fit 64 bits exactly
          fx = clamp_acc(uy * vz - uz * vy);
          fy = clamp_acc(uz * vx - ux * vz);
          fz = clamp_acc(ux * vy - uy * vx);
          corner[0] = b.index_a;
          corner[1] = b.index_b;
          corner[2] = b.index_c;
          for (int k = 0; k < 3; k++) begin
            sum_x[corner[k]] = clamp_acc(sum_x[corner[k]] + fx);
            sum_y[corner[k]] = clamp_acc(sum_y[corner[k]] + fy);
            sum_z[corner[k]] = clamp_acc(sum_z[corner[k]] + fz);
          end
        end else begin
          r.status = StatSkip;
        end
      end
      CmdRead: begin
        if (index_ok(b.index_a)) begin
          r = unit_normal(sum_x[b.index_a], sum_y[b.index_a], sum_z[b.index_a]);
          if (r.zero_normal) zero_reads++;
          if (sum_x[b.index_a] inside {AccHi, AccLo} ||
              sum_y[b.index_a] inside {AccHi, AccLo} ||
              sum_z[b.index_a] inside {AccHi, AccLo}) sat_reads++;
        end else begin
          r.status = StatRange;
        end
      end
      default: begin
        for (int i = 0; i < NumVerts; i++) begin
          sum_x[i] = 0;
          sum_y[i] = 0;
          sum_z[i] = 0;
        end
      end
    endcase
    return r;
  endfunction

  // Driver: predict on each accepted beat, then present the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_beats.insert(expected_beats.size(), apply_command(in_data_i));
        cmd_seen[in_data_i.command]++;
        beats_in++;
      end
      // hold the current beat until it is taken
      if (!in_valid_i || in_ready_o) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data_i  <= pending_beats.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and compare each result beat with the oldest
  // prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        beats_out++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data_o);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data_o.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, out_data_o.status);
            errors++;
          end
          if (out_data_o.normal_x !== want.normal_x) begin
            $display("%0t: normal_x exp %0d got %0d", $time, want.normal_x,
                     out_data_o.normal_x);
            errors++;
          end
          if (out_data_o.normal_y !== want.normal_y) begin
            $display("%0t: normal_y exp %0d got %0d", $time, want.normal_y,
                     out_data_o.normal_y);
            errors++;
          end
          if (out_data_o.normal_z !== want.normal_z) begin
            $display("%0t: normal_z exp %0d got %0d", $time, want.normal_z,
                     out_data_o.normal_z);
            errors++;
          end
          if (out_data_o.zero_normal !== want.zero_normal) begin
            $display("%0t: zero_normal exp %0d got %0d", $time, want.zero_normal,
                     out_data_o.zero_normal);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_beats.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Write vertex_count through the register port, then read it back.
  task automatic write_vcount(input int value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * RegVcount);
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    vcount_model = value & 32'h7ff;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(vcount_model)) begin
      $display("%0t: vertex_count readback exp %0d got %0d", $time, vcount_model, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic in_beat_t make_beat(input cmd_e cmd, input int a, input int b,
                                         input int c, input int x, input int y,
                                         input int z);
    in_beat_t t;
    t.command = cmd;
    t.index_a = 16'(a);
    t.index_b = 16'(b);
    t.index_c = 16'(c);
    t.coord_x = 24'(x);
    t.coord_y = 24'(y);
    t.coord_z = 24'(z);
    return t;
  endfunction

  function automatic int live_limit();
    return (vcount_model < NumVerts) ? vcount_model : NumVerts;
  endfunction

  // Queue a beat; a valid write marks its vertex as holding a position.
  task automatic queue_beat(input in_beat_t t);
    if (t.command == CmdWrite && t.index_a < live_limit() && !written[t.index_a]) begin
      written[t.index_a] = 1'b1;
      written_list.insert(written_list.size(), t.index_a);
    end
    pending_beats.insert(pending_beats.size(), t);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(7))
      0:       return -8388608;
      1:       return 8388607;
      2:       return $urandom_range(8191) - 4096;
      default: return int'($urandom) >>> 8;
    endcase
  endfunction

  function automatic int bad_index();
    if ($urandom_range(1)) return $urandom_range(65535, live_limit());
    return live_limit() + $urandom_range(3);
  endfunction

  // Pick a written vertex that is valid under the current vertex_count.
  function automatic int pick_written();
    int live[$];
    foreach (written_list[i])
      if (written_list[i] < live_limit()) live.insert(live.size(), written_list[i]);
    if (live.size() == 0) return -1;
    return live[$urandom_range(live.size() - 1)];
  endfunction

  function automatic int pick_valid();
    int n;
    n = live_limit();
    if ($urandom_range(9) < 7) return $urandom_range((n < 24 ? n : 24) - 1);
    return $urandom_range(n - 1);
  endfunction

  task automatic queue_random(input int count);
    int a, b, c, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (live_limit() == 0) begin
        // nothing is valid: every command must be refused or be a clear
        queue_beat(make_beat(cmd_e'($urandom_range(3)), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
      end else if (sel < 25) begin
        queue_beat(make_beat(CmdWrite, pick_valid(), $urandom, $urandom,
                             rand_coord(), rand_coord(), rand_coord()));
      end else if (sel < 62 && pick_written() >= 0) begin
        a = pick_written();
        b = pick_written();
        c = pick_written();
        queue_beat(make_beat(CmdFace, a, b, c, $urandom, $urandom, $urandom));
      end else if (sel < 88) begin
        queue_beat(make_beat(CmdRead, pick_valid(), $urandom, $urandom,
                             $urandom, $urandom, $urandom));
      end else if (sel < 91) begin
        queue_beat(make_beat(cmd_e'($urandom_range(1) ? CmdWrite : CmdRead), bad_index(),
                             $urandom, $urandom, $urandom, $urandom, $urandom));
      end else if (sel < 97) begin
        // broken face: at least one corner out of range, the rest written
        a = pick_written();
        if (a < 0) a = bad_index();
        b = pick_written();
        if (b < 0) b = bad_index();
        case ($urandom_range(2))
          0: a = bad_index();
          1: b = bad_index();
          default: c = bad_index();
        endcase
        if (c < live_limit() && !written[c]) c = bad_index();
        queue_beat(make_beat(CmdFace, a, b, c, $urandom, $urandom, $urandom));
        c = 0;
      end else begin
        queue_beat(make_beat(CmdClear, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom));
      end
    end
  endtask

  // Repeat one large face until its corner accumulators saturate, read two of
  // the corners, then clear and read one again.
  task automatic queue_saturation();
    queue_beat(make_beat(CmdWrite, 4, 0, 0, 0, -8388608, 0));
    queue_beat(make_beat(CmdWrite, 5, 0, 0, 0, 8388607, 8388607));
    queue_beat(make_beat(CmdWrite, 6, 0, 0, 0, 8388607, -8388608));
    for (int i = 0; i < 132; i++)
      queue_beat(make_beat(i[0] ? CmdFace : CmdFace, 4, 5, 6, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 4, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 6, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdClear, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 4, 0, 0, 0, 0, 0));
  endtask

  // Wait until the block has drained every queued beat and result.
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid_i || expected_beats.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NumVerts; i++) begin
      vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
      sum_x[i]  = 0; sum_y[i]  = 0; sum_z[i]  = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty mesh: every index is out of range.
    send_idle = 35;
    recv_idle = 58;
    write_vcount(0);
    queue_beat(make_beat(CmdWrite, 0, 0, 0, 1, 2, 3));
    queue_beat(make_beat(CmdFace, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdClear, 0, 0, 0, 0, 0, 0));
    queue_random(20);
    drain();

    // Full mesh: extremes, degenerate face, bad corners, zero reads.
    write_vcount(1024);
    queue_beat(make_beat(CmdWrite, 0, 0, 0, -8388608, -8388608, -8388608));
    queue_beat(make_beat(CmdWrite, 1023, 65535, 65535, 8388607, 8388607, 8388607));
    queue_beat(make_beat(CmdWrite, 1, 0, 0, 8388607, -8388608, 4096));
    queue_beat(make_beat(CmdWrite, 1024, 0, 0, 5, 5, 5));
    queue_beat(make_beat(CmdRead, 1023, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdFace, 0, 1, 1023, 0, 0, 0));
    queue_beat(make_beat(CmdFace, 0, 0, 1, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 1, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 1023, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 65535, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdFace, 0, 1, 65535, 0, 0, 0));
    queue_beat(make_beat(CmdFace, 65535, 1, 0, 0, 0, 0));
    queue_beat(make_beat(CmdFace, 1, 1024, 0, 0, 0, 0));
    queue_random(60);
    queue_saturation();
    drain();

    // Register above the store size: the store bounds the valid indices.
    send_idle = 58;
    recv_idle = 35;
    write_vcount(2047);
    queue_beat(make_beat(CmdRead, 1023, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdRead, 1024, 0, 0, 0, 0, 0));
    queue_beat(make_beat(CmdWrite, 1024, 0, 0, 7, 7, 7));
    queue_random(60);
    drain();

    // Smallest usable mesh; pause the sender mid-phase until all results land.
    write_vcount(3);
    queue_random(40);
    drain();
    queue_random(40);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_vcount(24);
    queue_random(50);
    drain();

    write_vcount(1024);
    queue_random(20);
    drain();

    $display("Covered %0d beats in / %0d out: write %0d, face %0d, read %0d, clear %0d",
             beats_in, beats_out, cmd_seen[CmdWrite], cmd_seen[CmdFace],
             cmd_seen[CmdRead], cmd_seen[CmdClear]);
    $display("Zero-sum reads %0d, saturated-sum reads %0d, vertex_count 0..2047",
             zero_reads, sat_reads);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
